@@ src/gbs_pkg.sv @@
`timescale 1ns / 1ps

package gbs_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_COLS_DEF  = 256;
	localparam int MAX_ROWS_DEF  = 256;
	localparam int FRAC_BITS_DEF = 8;

	// Fixed field widths of the request and result.
	localparam int QUERY_W     = 21;
	localparam int CELL_W      = 24;
	localparam int CELL_FRAC   = 4;
	localparam int IDX_W       = 8;
	localparam int CFG_W       = 9;
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 24;

	// Nodata marker in grid units and as a result with its fraction bits.
	localparam int GRID_NODATA = -9999;
	localparam logic signed [CELL_W-1:0] NODATA_ELEV = CELL_W'(GRID_NODATA * (2 ** CELL_FRAC));

	// Request kinds carried on tuser.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic REG_GRID_COLS = 1'b0;
	localparam logic REG_GRID_ROWS = 1'b1;
	localparam logic [CFG_W-1:0] GRID_SIZE_RST = 9'd256;

	// Result buffer depth, a power of two.
	localparam int OUT_DEPTH = 8;

	// Query control handed from the issue stage to the arithmetic pipeline.
	typedef struct packed {
		logic valid;
		logic no_data;
	} gbs_ctl_t;

endpackage

@@ src/grid_bilinear_sampler_top.sv @@
`timescale 1ns / 1ps

// Bilinear sampler over a stored elevation grid. A request with tuser 0 writes one cell;
// a request with tuser 1 queries the interpolated elevation at a signed fixed-point
// position; the input is held while the top row of its neighborhood is read, then the
// bottom row, because the four neighbor cells come from the one grid memory through its two
// read ports, one row of the neighborhood per cycle. A query's result passes the issue stage
// and the interpolation pipeline, then waits in an eight-entry result buffer, so input
// requests keep flowing while the output is stalled until that buffer is spoken for. Cells
// must be written before a query reads them; the grid memory is not cleared at reset and no clearing pass runs.
module grid_bilinear_sampler_top import gbs_pkg::*; #(
	parameter int MAX_COLS  = MAX_COLS_DEF,
	parameter int MAX_ROWS  = MAX_ROWS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// cell_col[7:0], cell_row[15:8], cell_value[39:16], query_x[60:40], query_y[81:61]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// mode[0]
	input  logic [0:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// elevation[23:0]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// no_data[0]
	output logic [0:0]             m_axis_tuser,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int AW    = CW + RW;
	localparam int CRD_W = $clog2(OUT_DEPTH + 1);

	logic                        in_fire, out_fire, busy;
	logic [CFG_W-1:0]            grid_cols_q, grid_rows_q;
	logic [CRD_W-1:0]            pending_q;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr, raddr_a, raddr_b;
	logic signed [CELL_W-1:0]    mem_wdata, rdata_a, rdata_b;
	gbs_ctl_t                    ctl;
	logic signed [FRAC_BITS:0]   fx, fy;
	logic signed [FRAC_BITS+1:0] omfx, omfy;
	logic                        push, push_nd, out_nd;
	logic signed [CELL_W-1:0]    push_elev, out_elev;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= GRID_SIZE_RST;
			grid_rows_q <= GRID_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr[0])
				REG_GRID_COLS: grid_cols_q <= cfg_wdata;
				REG_GRID_ROWS: grid_rows_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Queries in flight or buffered; a query is taken only if its result has a slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			priority if (in_fire && s_axis_tuser[0] == MODE_QUERY && !out_fire) begin
				pending_q <= pending_q + CRD_W'(1);
			end else if (!(in_fire && s_axis_tuser[0] == MODE_QUERY) && out_fire) begin
				pending_q <= pending_q - CRD_W'(1);
			end else begin
				pending_q <= pending_q;
			end
		end
	end

	assign s_axis_tready = !busy && (pending_q < CRD_W'(OUT_DEPTH));

	gbs_issue #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_issue (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.mode       (s_axis_tuser[0]),
		.cell_col   (s_axis_tdata[7:0]),
		.cell_row   (s_axis_tdata[15:8]),
		.cell_value (s_axis_tdata[39:16]),
		.query_x    (s_axis_tdata[60:40]),
		.query_y    (s_axis_tdata[81:61]),
		.grid_cols  (grid_cols_q),
		.grid_rows  (grid_rows_q),
		.busy       (busy),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.raddr_a    (raddr_a),
		.raddr_b    (raddr_b),
		.ctl        (ctl),
		.fx         (fx),
		.fy         (fy),
		.omfx       (omfx),
		.omfy       (omfy)
	);

	gbs_grid_mem #(
		.AW (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	gbs_interp #(
		.FRAC_BITS (FRAC_BITS)
	) u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.fx        (fx),
		.fy        (fy),
		.omfx      (omfx),
		.omfy      (omfy),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.push      (push),
		.push_elev (push_elev),
		.push_nd   (push_nd)
	);

	gbs_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_elev (push_elev),
		.push_nd   (push_nd),
		.pop       (out_fire),
		.valid     (m_axis_tvalid),
		.elev      (out_elev),
		.nd        (out_nd)
	);

	assign m_axis_tdata = out_elev;
	assign m_axis_tuser = out_nd;

endmodule

@@ src/gbs_grid_mem.sv @@
`timescale 1ns / 1ps

module gbs_grid_mem import gbs_pkg::*; #(
	parameter int AW = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [CELL_W-1:0] wdata,
	input  logic [AW-1:0]            raddr_a,
	input  logic [AW-1:0]            raddr_b,
	output logic signed [CELL_W-1:0] rdata_a,
	output logic signed [CELL_W-1:0] rdata_b
);

	logic signed [CELL_W-1:0] grid_mem [2**AW];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			grid_mem[waddr] <= wdata;
		end
	end

	// Two registered read ports; a read at the address being written returns the old data.
	always_ff @(posedge clk) begin
		rdata_a <= grid_mem[raddr_a];
		rdata_b <= grid_mem[raddr_b];
	end

endmodule

@@ src/gbs_issue.sv @@
`timescale 1ns / 1ps

module gbs_issue import gbs_pkg::*; #(
	parameter int MAX_COLS  = MAX_COLS_DEF,
	parameter int MAX_ROWS  = MAX_ROWS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int CW = $clog2(MAX_COLS),
	localparam int RW = $clog2(MAX_ROWS),
	localparam int AW = CW + RW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        mode,
	input  logic [IDX_W-1:0]            cell_col,
	input  logic [IDX_W-1:0]            cell_row,
	input  logic signed [CELL_W-1:0]    cell_value,
	input  logic signed [QUERY_W-1:0]   query_x,
	input  logic signed [QUERY_W-1:0]   query_y,
	input  logic [CFG_W-1:0]            grid_cols,
	input  logic [CFG_W-1:0]            grid_rows,
	output logic                        busy,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic signed [CELL_W-1:0]    mem_wdata,
	output logic [AW-1:0]               raddr_a,
	output logic [AW-1:0]               raddr_b,
	output gbs_ctl_t                    ctl,
	output logic signed [FRAC_BITS:0]   fx,
	output logic signed [FRAC_BITS:0]   fy,
	output logic signed [FRAC_BITS+1:0] omfx,
	output logic signed [FRAC_BITS+1:0] omfy
);

	localparam int IW    = QUERY_W - 1 - FRAC_BITS;
	localparam int LWC   = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
	localparam int LWR   = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
	localparam int CMPWC = ((IW > LWC) ? IW : LWC) + 1;
	localparam int CMPWR = ((IW > LWR) ? IW : LWR) + 1;
	localparam logic signed [FRAC_BITS+1:0] ONE_FX = {2'b01, {FRAC_BITS{1'b0}}};

	logic               query_fire;
	logic               x_neg, y_neg, x_in_ok, y_in_ok, x_out, y_out;
	logic [IW-1:0]      x_int, y_int;
	logic [LWC-1:0]     eff_cols;
	logic [LWR-1:0]     eff_rows;
	logic [FRAC_BITS:0] fx_in, fy_in;

	logic               valid_s1, phase_s1, nodata_s1;
	logic [CW-1:0]      x1_s1;
	logic [RW-1:0]      y1_s1;
	logic [RW-1:0]      row_rd;

	// Grid writes go straight to memory; cells beyond the storage are dropped.
	always_comb begin
		mem_we    = fire && (mode == MODE_WRITE) && (int'(cell_col) < MAX_COLS)
			&& (int'(cell_row) < MAX_ROWS);
		mem_waddr = {RW'(cell_row), CW'(cell_col)};
		mem_wdata = cell_value;
	end

	assign query_fire = fire && (mode == MODE_QUERY);

	// Grid size in use, clamped to the storage.
	always_comb begin
		eff_cols = (LWC'(grid_cols) > LWC'(MAX_COLS)) ? LWC'(MAX_COLS) : LWC'(grid_cols);
		eff_rows = (LWR'(grid_rows) > LWR'(MAX_ROWS)) ? LWR'(MAX_ROWS) : LWR'(grid_rows);
	end

	// Truncation toward zero. A negative coordinate above minus one truncates to zero
	// and keeps its negative fraction; anything lower is outside the grid.
	always_comb begin
		x_neg   = query_x[QUERY_W-1];
		y_neg   = query_y[QUERY_W-1];
		x_in_ok = (&query_x[QUERY_W-1:FRAC_BITS]) & (|query_x[FRAC_BITS-1:0]);
		y_in_ok = (&query_y[QUERY_W-1:FRAC_BITS]) & (|query_y[FRAC_BITS-1:0]);
		x_int   = x_neg ? '0 : query_x[QUERY_W-2:FRAC_BITS];
		y_int   = y_neg ? '0 : query_y[QUERY_W-2:FRAC_BITS];
		x_out   = (x_neg & ~x_in_ok) | (CMPWC'(x_int) + CMPWC'(1) >= CMPWC'(eff_cols));
		y_out   = (y_neg & ~y_in_ok) | (CMPWR'(y_int) + CMPWR'(1) >= CMPWR'(eff_rows));
		fx_in   = {x_neg, query_x[FRAC_BITS-1:0]};
		fy_in   = {y_neg, query_y[FRAC_BITS-1:0]};
	end

	// A query holds this stage while the top row is read, then the bottom row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (query_fire) begin
			valid_s1 <= 1'b1;
			phase_s1 <= 1'b0;
		end else if (valid_s1 && !phase_s1) begin
			phase_s1 <= 1'b1;
		end else begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			nodata_s1 <= x_out | y_out;
			x1_s1     <= CW'(x_int);
			y1_s1     <= RW'(y_int);
			fx        <= fx_in;
			fy        <= fy_in;
			omfx      <= ONE_FX - {fx_in[FRAC_BITS], fx_in};
			omfy      <= ONE_FX - {fy_in[FRAC_BITS], fy_in};
		end
	end

	// Read addresses for the current row of the 2x2 neighborhood.
	always_comb begin
		row_rd  = phase_s1 ? (y1_s1 + RW'(1)) : y1_s1;
		raddr_a = {row_rd, x1_s1};
		raddr_b = {row_rd, x1_s1 + CW'(1)};
	end

	assign busy        = valid_s1 && !phase_s1;
	assign ctl.valid   = valid_s1 && !phase_s1;
	assign ctl.no_data = nodata_s1;

endmodule

@@ src/gbs_interp.sv @@
`timescale 1ns / 1ps

module gbs_interp import gbs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gbs_ctl_t                    ctl,
	input  logic signed [FRAC_BITS:0]   fx,
	input  logic signed [FRAC_BITS:0]   fy,
	input  logic signed [FRAC_BITS+1:0] omfx,
	input  logic signed [FRAC_BITS+1:0] omfy,
	input  logic signed [CELL_W-1:0]    rdata_a,
	input  logic signed [CELL_W-1:0]    rdata_b,
	output logic                        push,
	output logic signed [CELL_W-1:0]    push_elev,
	output logic                        push_nd
);

	localparam int WW  = 2 * FRAC_BITS + 4;
	localparam int PW  = CELL_W + WW;
	localparam int SW  = PW + 2;
	localparam int RSW = SW - 2 * FRAC_BITS;
	localparam logic signed [SW-1:0] RND =
		{{(SW - 2 * FRAC_BITS){1'b0}}, 1'b1, {(2 * FRAC_BITS - 1){1'b0}}};
	localparam logic signed [CELL_W-1:0] ELEV_MAX = {1'b0, {(CELL_W-1){1'b1}}};
	localparam logic signed [CELL_W-1:0] ELEV_MIN = {1'b1, {(CELL_W-1){1'b0}}};

	logic                     v_s2, v_s3, v_s4, v_s5;
	logic                     nd_s2, nd_s3, nd_s4, nd_s5;
	logic signed [WW-1:0]     w11_s2, w21_s2, w12_s2, w22_s2;
	logic signed [WW-1:0]     w12_s3, w22_s3;
	logic signed [PW-1:0]     pa_s3, pb_s3;
	logic signed [PW-1:0]     p11_s4, p21_s4, p12_s4, p22_s4;
	logic signed [SW-1:0]     sa_s5, sb_s5;
	logic signed [SW-1:0]     total;
	logic signed [RSW-1:0]    rnd;
	logic                     fits;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= ctl.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 2: the four corner weights; the top row is being read meanwhile.
	// Stage 3: top row arrives and is weighted; the bottom row is being read.
	// Stage 4: bottom row weighted. Stage 5: pairwise sums with the rounding offset.
	always_ff @(posedge clk) begin
		nd_s2  <= ctl.no_data;
		w11_s2 <= omfx * omfy;
		w21_s2 <= fx * omfy;
		w12_s2 <= omfx * fy;
		w22_s2 <= fx * fy;

		nd_s3  <= nd_s2;
		pa_s3  <= rdata_a * w11_s2;
		pb_s3  <= rdata_b * w21_s2;
		w12_s3 <= w12_s2;
		w22_s3 <= w22_s2;

		nd_s4  <= nd_s3;
		p11_s4 <= pa_s3;
		p21_s4 <= pb_s3;
		p12_s4 <= rdata_a * w12_s3;
		p22_s4 <= rdata_b * w22_s3;

		nd_s5  <= nd_s4;
		sa_s5  <= p11_s4 + p21_s4;
		sb_s5  <= p12_s4 + p22_s4 + RND;
	end

	// Final sum, floor shift, and saturation to the result width; a nodata query gives the nodata elevation.
	always_comb begin
		total = sa_s5 + sb_s5;
		rnd   = total[SW-1:2*FRAC_BITS];
		fits  = (&rnd[RSW-1:CELL_W-1]) | ~(|rnd[RSW-1:CELL_W-1]);
		push  = v_s5;
		push_nd = nd_s5;
		if (nd_s5) begin
			push_elev = NODATA_ELEV;
		end else if (fits) begin
			push_elev = rnd[CELL_W-1:0];
		end else begin
			push_elev = rnd[RSW-1] ? ELEV_MIN : ELEV_MAX;
		end
	end

endmodule

@@ src/gbs_out_fifo.sv @@
`timescale 1ns / 1ps

module gbs_out_fifo import gbs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic signed [CELL_W-1:0] push_elev,
	input  logic                     push_nd,
	input  logic                     pop,
	output logic                     valid,
	output logic signed [CELL_W-1:0] elev,
	output logic                     nd
);

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	logic signed [CELL_W-1:0] elev_q [OUT_DEPTH];
	logic                     nd_q   [OUT_DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]         count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (push) begin
			elev_q[wr_ptr_q] <= push_elev;
			nd_q[wr_ptr_q]   <= push_nd;
		end
	end

	assign valid = (count_q != '0);
	assign elev  = elev_q[rd_ptr_q];
	assign nd    = nd_q[rd_ptr_q];

endmodule

@@ src/gbs_checker.sv @@
`timescale 1ns / 1ps

module gbs_checker import gbs_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [0:0]             s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]             m_axis_tuser
);

	// A query holds off further requests while the top row of its neighborhood is read.
	a_query_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == MODE_QUERY) |=> !s_axis_tready)
		else $error("request accepted in the cycle after a query");

	// A nodata result always carries the nodata elevation.
	a_nodata_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == NODATA_ELEV))
		else $error("nodata result with a wrong elevation");

	// A stalled result holds its content.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

	// A write request creates no result: with nothing buffered, none appears next cycle.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		($past(!m_axis_tvalid, 5) && $past(!m_axis_tvalid, 4) && !m_axis_tvalid
			&& $past(!(s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == MODE_QUERY), 4)
			&& $past(!(s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == MODE_QUERY), 5)
			&& $past(!(s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == MODE_QUERY), 6))
		|=> !m_axis_tvalid)
		else $error("result appeared without a query");

endmodule

bind grid_bilinear_sampler_top gbs_checker u_gbs_checker (.*);

@@ tb/grid_bilinear_sampler_top_tb.sv @@
`timescale 1ns / 1ps

module grid_bilinear_sampler_top_tb;
	import gbs_pkg::*;

	localparam int MAX_COLS = MAX_COLS_DEF;
	localparam int MAX_ROWS = MAX_ROWS_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) <<< FRAC;
	localparam longint SAT_MAX = 64'sd8388607;
	localparam longint SAT_MIN = -64'sd8388608;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [CELL_W-1:0] elev;
		logic              nd;
	} sample_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [0:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;
	logic                   cfg_we;
	logic [0:0]             cfg_addr;
	logic [CFG_W-1:0]       cfg_wdata;

	// Mirror of the grid and the size registers.
	logic signed [CELL_W-1:0] grid_mem [0:MAX_ROWS*MAX_COLS-1];
	bit                       cell_written [0:MAX_ROWS*MAX_COLS-1];
	bit                       base_ready [0:MAX_ROWS*MAX_COLS-1];
	int                       base_list [$];
	int                       grid_cols_cfg = GRID_SIZE_RST;
	int                       grid_rows_cfg = GRID_SIZE_RST;

	sample_t expected_samples [$];

	bit src_idle_en = 1'b1;
	bit sink_idle_en = 1'b1;
	bit long_hold_req = 1'b0;
	int error_count = 0;
	int results_checked = 0;
	int n_writes = 0;
	int n_queries = 0;
	int n_nodata = 0;
	int size_settings = 0;

	grid_bilinear_sampler_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int eff_cols();
		return (grid_cols_cfg > MAX_COLS) ? MAX_COLS : grid_cols_cfg;
	endfunction

	function automatic int eff_rows();
		return (grid_rows_cfg > MAX_ROWS) ? MAX_ROWS : grid_rows_cfg;
	endfunction

	// Truncate the position toward zero and tell whether the 2x2 neighborhood is in the grid.
	function automatic bit grid_hit(input logic [QUERY_W-1:0] qx_b, input logic [QUERY_W-1:0] qy_b,
			output int x1, output int y1);
		int qx;
		int qy;
		qx = $signed(qx_b);
		qy = $signed(qy_b);
		x1 = (qx >= 0) ? (qx >>> FRAC) : -((-qx) >>> FRAC);
		y1 = (qy >= 0) ? (qy >>> FRAC) : -((-qy) >>> FRAC);
		return !(x1 < 0 || x1 + 1 >= eff_cols() || y1 < 0 || y1 + 1 >= eff_rows());
	endfunction

	// A query is legal when it lands outside the grid or on four written cells.
	function automatic bit neighborhood_readable(input logic [QUERY_W-1:0] qx,
			input logic [QUERY_W-1:0] qy);
		int x1;
		int y1;
		int idx;
		if (!grid_hit(qx, qy, x1, y1))
			return 1'b1;
		idx = y1 * MAX_COLS + x1;
		return cell_written[idx] && cell_written[idx + 1] &&
			cell_written[idx + MAX_COLS] && cell_written[idx + MAX_COLS + 1];
	endfunction

	// Weighted sum of the four neighbors, rounded half up and clamped to 24 bits.
	function automatic sample_t predict_sample(input logic [QUERY_W-1:0] qx_b,
			input logic [QUERY_W-1:0] qy_b);
		sample_t s;
		int x1;
		int y1;
		int idx;
		longint fx;
		longint fy;
		longint acc;
		s.elev = NODATA_ELEV;
		s.nd = 1'b1;
		if (grid_hit(qx_b, qy_b, x1, y1)) begin
			fx = longint'($signed(qx_b)) - (longint'(x1) <<< FRAC);
			fy = longint'($signed(qy_b)) - (longint'(y1) <<< FRAC);
			idx = y1 * MAX_COLS + x1;
			acc = grid_mem[idx] * ((ONE - fx) * (ONE - fy))
				+ grid_mem[idx + 1] * (fx * (ONE - fy))
				+ grid_mem[idx + MAX_COLS] * ((ONE - fx) * fy)
				+ grid_mem[idx + MAX_COLS + 1] * (fx * fy);
			acc = (acc + (longint'(1) <<< (2 * FRAC - 1))) >>> (2 * FRAC);
			if (acc > SAT_MAX)
				acc = SAT_MAX;
			if (acc < SAT_MIN)
				acc = SAT_MIN;
			s.elev = acc[CELL_W-1:0];
			s.nd = 1'b0;
		end
		return s;
	endfunction

	// Store a cell and register every 2x2 base that it completes.
	function automatic void store_cell(input int col, input int row, input logic [CELL_W-1:0] value);
		int r0;
		int c0;
		int idx;
		grid_mem[row * MAX_COLS + col] = value;
		cell_written[row * MAX_COLS + col] = 1'b1;
		for (int dr = -1; dr <= 0; dr++) begin
			for (int dc = -1; dc <= 0; dc++) begin
				r0 = row + dr;
				c0 = col + dc;
				if (r0 >= 0 && c0 >= 0 && r0 < MAX_ROWS - 1 && c0 < MAX_COLS - 1) begin
					idx = r0 * MAX_COLS + c0;
					if (!base_ready[idx] && cell_written[idx] && cell_written[idx + 1] &&
							cell_written[idx + MAX_COLS] && cell_written[idx + MAX_COLS + 1]) begin
						base_ready[idx] = 1'b1;
						base_list.insert(base_list.size(), idx);
					end
				end
			end
		end
	endfunction

	// Offer one request, with an optional idle burst first, and update the mirror on acceptance.
	task automatic send_request(input logic mode, input logic [IDX_W-1:0] col,
			input logic [IDX_W-1:0] row, input logic [CELL_W-1:0] value,
			input logic [QUERY_W-1:0] qx, input logic [QUERY_W-1:0] qy);
		sample_t s;
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {6'b0, qy, qx, value, row, col};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (mode == MODE_WRITE) begin
			store_cell(col, row, value);
			n_writes++;
		end else begin
			s = predict_sample(qx, qy);
			expected_samples.insert(expected_samples.size(), s);
			n_queries++;
			if (s.nd)
				n_nodata++;
		end
		@(negedge clk);
	endtask

	task automatic write_cell(input int col, input int row, input logic [CELL_W-1:0] value);
		send_request(MODE_WRITE, IDX_W'(col), IDX_W'(row), value, QUERY_W'($urandom),
			QUERY_W'($urandom));
	endtask

	task automatic query_at(input logic [QUERY_W-1:0] qx, input logic [QUERY_W-1:0] qy);
		send_request(MODE_QUERY, IDX_W'($urandom), IDX_W'($urandom), CELL_W'($urandom), qx, qy);
	endtask

	// Writes go mostly near the origin, some near the edge of the grid in use, some anywhere.
	task automatic send_random_write();
		int pick;
		int c;
		int r;
		logic [CELL_W-1:0] v;
		pick = $urandom_range(0, 9);
		if (pick <= 5) begin
			c = $urandom_range(0, 11);
			r = $urandom_range(0, 11);
		end else if (pick <= 7) begin
			c = eff_cols() - 1 - $urandom_range(0, 2);
			r = eff_rows() - 1 - $urandom_range(0, 2);
			if (c < 0)
				c = 0;
			if (r < 0)
				r = 0;
		end else begin
			c = $urandom_range(0, MAX_COLS - 1);
			r = $urandom_range(0, MAX_ROWS - 1);
		end
		case ($urandom_range(0, 7))
			0: v = 24'h7FFFFF;
			1: v = 24'h800000;
			default: v = CELL_W'($urandom);
		endcase
		write_cell(c, r, v);
	endtask

	// Queries mostly hit written neighborhoods; the rest probe the grid edge or are raw noise.
	task automatic send_random_query();
		int pick;
		int base;
		int x1;
		int y1;
		int fx;
		int fy;
		logic [QUERY_W-1:0] qx;
		logic [QUERY_W-1:0] qy;
		pick = $urandom_range(0, 9);
		if (pick <= 6 && base_list.size() > 0) begin
			base = base_list[$urandom_range(0, base_list.size() - 1)];
			x1 = base % MAX_COLS;
			y1 = base / MAX_COLS;
			fx = $urandom_range(0, 255);
			fy = $urandom_range(0, 255);
			// At column or row zero a small negative position still truncates to zero.
			if (x1 == 0 && $urandom_range(0, 3) == 0)
				qx = QUERY_W'(-fx);
			else
				qx = QUERY_W'(x1 * ONE + fx);
			if (y1 == 0 && $urandom_range(0, 3) == 0)
				qy = QUERY_W'(-fy);
			else
				qy = QUERY_W'(y1 * ONE + fy);
		end else if (pick == 7) begin
			x1 = eff_cols() - 3 + $urandom_range(0, 3);
			y1 = eff_rows() - 3 + $urandom_range(0, 3);
			qx = QUERY_W'(x1 * ONE + $urandom_range(0, 255));
			qy = QUERY_W'(y1 * ONE + $urandom_range(0, 255));
		end else begin
			qx = QUERY_W'($urandom);
			qy = QUERY_W'($urandom);
		end
		// Never read unwritten cells: push such a position far to the right of the grid.
		if (!neighborhood_readable(qx, qy))
			qx = {2'b01, 19'($urandom)};
		query_at(qx, qy);
	endtask

	task automatic send_random_item();
		if ($urandom_range(0, 99) < 45)
			send_random_write();
		else
			send_random_query();
	endtask

	// Let the block run dry, then write both size registers.
	task automatic set_grid_size(input int cols, input int rows);
		s_axis_tvalid <= 1'b0;
		wait (expected_samples.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_GRID_COLS;
		cfg_wdata <= CFG_W'(cols);
		@(negedge clk);
		cfg_addr <= REG_GRID_ROWS;
		cfg_wdata <= CFG_W'(rows);
		@(negedge clk);
		cfg_we <= 1'b0;
		grid_cols_cfg = cols;
		grid_rows_cfg = rows;
		size_settings++;
	endtask

	// Extreme values near the origin and in the far corner, rounding ties, extrapolation,
	// and positions just outside the grid.
	task automatic test_directed_corners();
		write_cell(0, 0, 24'h7FFFFF);
		write_cell(1, 0, 24'h800000);
		write_cell(0, 1, 24'h000000);
		write_cell(1, 1, 24'hFFFFFF);
		write_cell(254, 254, CELL_W'($urandom));
		write_cell(255, 254, 24'h7FFFFF);
		write_cell(254, 255, 24'h800000);
		write_cell(255, 255, CELL_W'($urandom));
		query_at(QUERY_W'(0), QUERY_W'(0));
		query_at(QUERY_W'(128), QUERY_W'(0));
		query_at(QUERY_W'(128), QUERY_W'(128));
		query_at(QUERY_W'(-255), QUERY_W'(0));
		query_at(QUERY_W'(-1), QUERY_W'(-128));
		query_at(QUERY_W'(255), QUERY_W'(255));
		query_at(QUERY_W'(254 * 256 + 255), QUERY_W'(254 * 256 + 255));
		query_at(QUERY_W'(255 * 256), QUERY_W'(0));
		query_at(QUERY_W'(-256), QUERY_W'(0));
		query_at(QUERY_W'(0), QUERY_W'(255 * 256));
		query_at(21'h0FFFFF, 21'h0FFFFF);
		query_at(21'h100000, 21'h100000);
	endtask

	// Size settings at and beyond the extremes, each with a short mixed run.
	task automatic test_grid_sizes();
		int sizes [7][2] = '{'{2, 2}, '{0, 256}, '{256, 1}, '{511, 511}, '{257, 2},
			'{3, 5}, '{256, 256}};
		for (int k = 0; k < 7; k++) begin
			set_grid_size(sizes[k][0], sizes[k][1]);
			query_at(QUERY_W'(128), QUERY_W'(128));
			query_at(QUERY_W'(254 * 256 + 128), QUERY_W'(254 * 256 + 128));
			repeat (28)
				send_random_item();
		end
	endtask

	// Long random mix over random grid sizes; one segment runs without idling.
	task automatic test_random_mix();
		int cols;
		int rows;
		for (int seg = 0; seg < 5; seg++) begin
			case ($urandom_range(0, 7))
				0: cols = $urandom_range(0, 1);
				1: cols = $urandom_range(257, 511);
				default: cols = $urandom_range(2, 256);
			endcase
			case ($urandom_range(0, 7))
				0: rows = $urandom_range(0, 1);
				1: rows = $urandom_range(257, 511);
				default: rows = $urandom_range(2, 256);
			endcase
			set_grid_size(cols, rows);
			src_idle_en = (seg != 2);
			sink_idle_en = (seg != 2);
			repeat (200)
				send_random_item();
		end
	endtask

	// The output stalls for a long stretch while queries keep coming, filling the block.
	task automatic test_output_backpressure();
		set_grid_size(256, 256);
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		long_hold_req = 1'b1;
		repeat (70)
			send_random_query();
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		set_grid_size($urandom_range(2, 256), $urandom_range(2, 256));
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		repeat (250)
			send_random_item();
	endtask

	// Output ready: random idle bursts, or one long hold when requested.
	initial begin : result_sink
		bit hold_taken;
		hold_taken = 1'b0;
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest expected sample.
	initial begin : result_check
		sample_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result elevation=%0d no_data=%0b", $time,
						$signed(m_axis_tdata), m_axis_tuser);
				end else begin
					want = expected_samples.pop_front();
					results_checked++;
					if (m_axis_tdata !== want.elev) begin
						error_count++;
						$display("%0t: elevation expected %0d, got %0d", $time,
							$signed(want.elev), $signed(m_axis_tdata));
					end
					if (m_axis_tuser[0] !== want.nd) begin
						error_count++;
						$display("%0t: no_data expected %0b, got %0b", $time, want.nd,
							m_axis_tuser[0]);
					end
				end
			end
		end
	end

	// Stop the run if neither side accepts anything for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, nothing accepted for %0d cycles", $time, STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : run
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_WRITE;
		cfg_we = 1'b0;
		cfg_addr = REG_GRID_COLS;
		cfg_wdata = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_corners();
		test_grid_sizes();
		test_random_mix();
		test_output_backpressure();
		test_full_rate();

		// Drain the remaining results before the verdict.
		s_axis_tvalid <= 1'b0;
		wait (expected_samples.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d cell writes and %0d queries (%0d outside the grid)", n_writes,
			n_queries, n_nodata);
		$display("over %0d grid size settings; %0d results checked, %0d errors", size_settings,
			results_checked, error_count);
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
